// ----- rtl/amgs_pkg.sv -----
// ----------------------------------------------------------------------------
// amgs_pkg
// Shared widths, command and status codes for the adjacency matrix graph store.
// ----------------------------------------------------------------------------
package amgs_pkg;

    localparam int MAX_VERTICES_DEF = 16;

    localparam int CMD_W  = 3;
    localparam int VTX_W  = 4;
    localparam int STAT_W = 3;
    localparam int EDGE_W = 9;
    localparam int VTOT_W = 5;
    localparam int LIST_W = 16;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [VTX_W-1:0]  t_vertex;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic [EDGE_W-1:0] t_edge_total;
    typedef logic [VTOT_W-1:0] t_vertex_total;

    localparam t_cmd CMD_INSERT = 3'd0;
    localparam t_cmd CMD_DELETE = 3'd1;
    localparam t_cmd CMD_QUERY  = 3'd2;
    localparam t_cmd CMD_ADD    = 3'd3;
    localparam t_cmd CMD_REMOVE = 3'd4;
    localparam t_cmd CMD_LIST   = 3'd5;

    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_PRESENT = 3'd1;
    localparam t_status ST_ABSENT  = 3'd2;
    localparam t_status ST_INVALID = 3'd3;
    localparam t_status ST_FULL    = 3'd4;

    localparam t_edge_total EDGE_LIMIT = 9'd256;

endpackage

// ----- rtl/amgs_row_mem.sv -----
// ----------------------------------------------------------------------------
// amgs_row_mem
// Row store of the adjacency matrix: one write and one read port, registered
// read data, and a valid bit per row so that unwritten rows read as zero.
// ----------------------------------------------------------------------------
module amgs_row_mem #(
    parameter int DEPTH = amgs_pkg::MAX_VERTICES_DEF,
    parameter int WIDTH = amgs_pkg::MAX_VERTICES_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_ok <= r_valid[i_raddr];
            end
        end
    end

    // never-written rows read as the cleared matrix
    assign o_rdata = r_rd_ok ? r_rdata : '0;

endmodule

// ----- rtl/adjacency_matrix_graph_store.sv -----
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store
// Bit adjacency matrix with vertex and edge counts, driven by one command per
// start pulse. Query reads a row; insert and delete take one read-modify-write
// of a row (a second one for the mirrored row in undirected mode), the result
// registered out of the edge state, or the mirror state when mirrored. Add
// vertex, unknown codes and any command naming an invalid vertex strobe the
// cycle after start. Remove vertex walks every stored row through the row
// memory port, one row a cycle, compacting as it goes, then strobes the
// result. Listing reads the row once and then tests one column a cycle, giving
// one result per neighbour, or one empty result when there is none; it ends on
// the highest neighbour. busy is high while a command is in flight; the
// receiver cannot stall, so every result stands on the ports for the single
// cycle that o_strobe is high. The matrix is clear right after reset with no
// clearing pass. The configuration channel is ready only while busy is low.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_store #(
    parameter int MAX_VERTICES = amgs_pkg::MAX_VERTICES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  amgs_pkg::t_cmd          i_command,
    input  amgs_pkg::t_vertex       i_source_vertex,
    input  amgs_pkg::t_vertex       i_target_vertex,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic                    i_cfg_data,
    output logic                    o_strobe,
    output amgs_pkg::t_status       o_status,
    output logic                    o_edge_present,
    output amgs_pkg::t_vertex       o_neighbour_index,
    output logic                    o_neighbour_valid,
    output logic                    o_last_result,
    output amgs_pkg::t_edge_total   o_edge_total,
    output amgs_pkg::t_vertex_total o_vertex_total
);

    import amgs_pkg::*;

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W  = (CNT_W > VTX_W) ? CNT_W : VTX_W;
    localparam int KV_W   = (ADDR_W > VTX_W) ? ADDR_W : VTX_W;
    localparam int GONE_W = $clog2(2 * MAX_VERTICES + 1);
    localparam int EXT_W  = (MAX_VERTICES > LIST_W) ? MAX_VERTICES : LIST_W;

    localparam logic [MAX_VERTICES-1:0] ROW_ONE = MAX_VERTICES'(1);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_EDGE      = 3'd1;
    localparam logic [2:0] S_MIRROR    = 3'd2;
    localparam logic [2:0] S_RM_WALK   = 3'd3;
    localparam logic [2:0] S_RM_LAST   = 3'd4;
    localparam logic [2:0] S_LIST_LOAD = 3'd5;
    localparam logic [2:0] S_LIST_SCAN = 3'd6;

    logic [2:0]          r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    t_vertex             r_u, n_u;
    t_vertex             r_v, n_v;
    logic [ADDR_W-1:0]   r_k, n_k;
    logic [GONE_W-1:0]   r_gone, n_gone;
    logic [LIST_W-1:0]   r_row, n_row;
    t_vertex             r_col, n_col;
    logic [CNT_W-1:0]    r_vc, n_vc;
    t_edge_total         r_ec, n_ec;
    logic                r_dir;
    logic                r_strobe;

    logic                emit;
    t_status             e_status;
    logic                e_present;
    t_vertex             e_nidx;
    logic                e_nvalid;
    logic                e_last;

    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [MAX_VERTICES-1:0] mem_wdata;
    logic                    mem_re;
    logic [ADDR_W-1:0]       mem_raddr;
    logic [MAX_VERTICES-1:0] mem_rdata;

    logic                    u_ok, v_ok, full, is_ins, rd_bit_v, k_is_v, k_more, scan_bit;
    logic [MAX_VERTICES-1:0] bit_u_mask, bit_v_mask, low_mask, dropped;
    logic [CNT_W-1:0]        row_pop;
    logic [EXT_W-1:0]        d_ext;
    logic [LIST_W-1:0]       win, scan_mask;

    amgs_row_mem #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (MAX_VERTICES)
    ) u_rows (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign u_ok   = CMP_W'(i_source_vertex) < CMP_W'(r_vc);
    assign v_ok   = CMP_W'(i_target_vertex) < CMP_W'(r_vc);
    assign full   = r_vc == CNT_W'(MAX_VERTICES);
    assign is_ins = r_cmd == CMD_INSERT;

    assign bit_u_mask = ROW_ONE << r_u;
    assign bit_v_mask = ROW_ONE << r_v;
    assign rd_bit_v   = |(mem_rdata & bit_v_mask);

    // close the gap left by column v: bits above it move down one place
    assign low_mask = bit_v_mask - ROW_ONE;
    assign dropped  = (mem_rdata & low_mask) | ((mem_rdata >> 1) & ~low_mask);

    assign k_is_v = KV_W'(r_k) == KV_W'(r_v);
    assign k_more = (CNT_W'(r_k) + CNT_W'(1)) < r_vc;

    assign d_ext     = EXT_W'(mem_rdata);
    assign win       = d_ext[LIST_W-1:0];
    assign scan_mask = LIST_W'(1) << r_col;
    assign scan_bit  = |(r_row & scan_mask);

    always_comb begin
        row_pop = '0;
        for (int j = 0; j < MAX_VERTICES; j++) begin
            row_pop = row_pop + CNT_W'(mem_rdata[j]);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_u       = r_u;
        n_v       = r_v;
        n_k       = r_k;
        n_gone    = r_gone;
        n_row     = r_row;
        n_col     = r_col;
        n_vc      = r_vc;
        n_ec      = r_ec;
        emit      = 1'b0;
        e_status  = ST_OK;
        e_present = 1'b0;
        e_nidx    = '0;
        e_nvalid  = 1'b0;
        e_last    = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd = i_command;
                    n_u   = i_source_vertex;
                    n_v   = i_target_vertex;
                    case (i_command)
                        CMD_INSERT, CMD_DELETE, CMD_QUERY: begin
                            if (u_ok && v_ok) begin
                                mem_re    = 1'b1;
                                mem_raddr = ADDR_W'(i_source_vertex);
                                n_state   = S_EDGE;
                            end else begin
                                emit     = 1'b1;
                                e_status = ST_INVALID;
                            end
                        end
                        CMD_ADD: begin
                            // rows and columns past the count are already clear
                            emit = 1'b1;
                            if (full) begin
                                e_status = ST_FULL;
                            end else begin
                                n_vc = r_vc + CNT_W'(1);
                            end
                        end
                        CMD_REMOVE: begin
                            if (v_ok) begin
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                                n_k       = '0;
                                n_gone    = '0;
                                n_state   = S_RM_WALK;
                            end else begin
                                emit     = 1'b1;
                                e_status = ST_INVALID;
                            end
                        end
                        CMD_LIST: begin
                            if (v_ok) begin
                                mem_re    = 1'b1;
                                mem_raddr = ADDR_W'(i_target_vertex);
                                n_state   = S_LIST_LOAD;
                            end else begin
                                emit     = 1'b1;
                                e_status = ST_INVALID;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end

            S_EDGE: begin
                if (r_cmd == CMD_QUERY) begin
                    emit      = 1'b1;
                    e_present = rd_bit_v;
                    n_state   = S_IDLE;
                end else if (is_ins == rd_bit_v) begin
                    emit     = 1'b1;
                    e_status = is_ins ? ST_PRESENT : ST_ABSENT;
                    n_state  = S_IDLE;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(r_u);
                    mem_wdata = is_ins ? (mem_rdata | bit_v_mask) : (mem_rdata & ~bit_v_mask);
                    if (is_ins) begin
                        if (r_ec < EDGE_LIMIT) begin
                            n_ec = r_ec + 9'd1;
                        end
                    end else if (r_ec != '0) begin
                        n_ec = r_ec - 9'd1;
                    end
                    // a self loop is its own mirror
                    if (!r_dir && (r_u != r_v)) begin
                        mem_re    = 1'b1;
                        mem_raddr = ADDR_W'(r_v);
                        n_state   = S_MIRROR;
                    end else begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end

            S_MIRROR: begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(r_v);
                mem_wdata = is_ins ? (mem_rdata | bit_u_mask) : (mem_rdata & ~bit_u_mask);
                emit      = 1'b1;
                n_state   = S_IDLE;
            end

            S_RM_WALK: begin
                // row k is on the read port; write it back one place down if past v, drop it if it is v
                if (k_is_v) begin
                    n_gone = r_gone + GONE_W'(row_pop);
                end else begin
                    n_gone    = r_gone + GONE_W'(r_dir && rd_bit_v);
                    mem_we    = 1'b1;
                    mem_waddr = (KV_W'(r_k) > KV_W'(r_v)) ? (r_k - ADDR_W'(1)) : r_k;
                    mem_wdata = dropped;
                end
                if (k_more) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_k + ADDR_W'(1);
                    n_k       = r_k + ADDR_W'(1);
                end else begin
                    n_state = S_RM_LAST;
                end
            end

            S_RM_LAST: begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(r_vc - CNT_W'(1));
                mem_wdata = '0;
                n_ec      = (EDGE_W'(r_gone) >= r_ec) ? '0 : (r_ec - EDGE_W'(r_gone));
                n_vc      = r_vc - CNT_W'(1);
                emit      = 1'b1;
                n_state   = S_IDLE;
            end

            S_LIST_LOAD: begin
                n_row = win;
                n_col = '0;
                if (win == '0) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_LIST_SCAN;
                end
            end

            S_LIST_SCAN: begin
                // drop each neighbour as it goes out; the last one ends the list
                if (scan_bit) begin
                    n_row    = r_row & ~scan_mask;
                    emit     = 1'b1;
                    e_nidx   = r_col;
                    e_nvalid = 1'b1;
                    e_last   = n_row == '0;
                    if (n_row == '0) begin
                        n_state = S_IDLE;
                    end
                end
                n_col = r_col + VTX_W'(1);
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vc     <= '0;
            r_ec     <= '0;
            r_dir    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_vc     <= n_vc;
            r_ec     <= n_ec;
            r_strobe <= emit;
            if (i_cfg_valid && o_cfg_ready) begin
                r_dir <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_u    <= n_u;
        r_v    <= n_v;
        r_k    <= n_k;
        r_gone <= n_gone;
        r_row  <= n_row;
        r_col  <= n_col;
        if (emit) begin
            o_status          <= e_status;
            o_edge_present    <= e_present;
            o_neighbour_index <= e_nidx;
            o_neighbour_valid <= e_nvalid;
            o_last_result     <= e_last;
        end
    end

    assign busy           = r_state != S_IDLE;
    // hold the mode word off while a command is walking the matrix
    assign o_cfg_ready    = !busy;
    assign o_strobe       = r_strobe;
    assign o_edge_total   = r_ec;
    assign o_vertex_total = VTOT_W'(r_vc);

    // a word that is not the last of its command leaves the block still working
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_result) |-> busy)
        else $error("non-final result with the block idle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_strobe || busy))
        else $error("accepted command neither answered nor in progress");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vc <= CNT_W'(MAX_VERTICES))
        else $error("vertex count past capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ec <= EDGE_LIMIT)
        else $error("edge count past its limit");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_neighbour_valid) |-> (o_status == ST_OK && !o_edge_present))
        else $error("neighbour word with a bad status");

endmodule
